@@ rtl/smcp_pkg.sv @@
package smcp_pkg;

    // Line capacity in bytes; a line keeps LINE_CAPACITY-1 bytes, CR and LF not counted.
    localparam int LINE_CAPACITY = 32;
    localparam int COUNT_W       = $clog2(LINE_CAPACITY);

    // Token queue between the front and back halves.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_S_LO  = 8'h73;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_P_LO  = 8'h70;
    localparam logic [7:0] CHAR_O     = 8'h4F;
    localparam logic [7:0] CHAR_O_LO  = 8'h6F;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    // Number accumulator saturates here, so every long number reads as out of range.
    localparam logic [8:0] ACC_SAT = 9'd256;

    typedef enum logic [2:0] {
        KIND_SET       = 3'd0,
        KIND_POWER_ON  = 3'd1,
        KIND_POWER_OFF = 3'd2,
        KIND_BAD_CH    = 3'd3,
        KIND_BAD_SP    = 3'd4,
        KIND_BAD_DIR   = 3'd5,
        KIND_NONE      = 3'd6
    } t_kind;

    // Byte classes; a zero byte falls in CLS_OTHER, and only a line feed (eol) ends the line.
    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_DIGIT,
        CLS_SET,
        CLS_PON,
        CLS_POFF,
        CLS_OTHER
    } t_cls;

    typedef struct packed {
        logic       eol;    // line feed: close the line and report
        t_cls       cls;
        logic [3:0] digit;
    } t_token;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_CH_SKIP,
        PH_CH_NUM,
        PH_SP_SKIP,
        PH_SP_NUM,
        PH_DIR_SKIP,
        PH_DIR_NUM,
        PH_DONE
    } t_phase;

endpackage

@@ rtl/smcp_front.sv @@
module smcp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_full,
    output logic                o_stall,
    output logic                o_push,
    output smcp_pkg::t_token    o_token
);
    import smcp_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               accept;
    logic               room;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign room    = (r_count < COUNT_W'(LINE_CAPACITY - 1));

    always_comb begin
        o_token.eol   = 1'b0;
        o_token.cls   = CLS_OTHER;
        o_token.digit = 4'(i_rx_byte - CHAR_0);
        unique case (i_rx_byte) inside
            CHAR_SPACE:          o_token.cls = CLS_SPACE;
            [CHAR_0:CHAR_9]:     o_token.cls = CLS_DIGIT;
            CHAR_S, CHAR_S_LO:   o_token.cls = CLS_SET;
            CHAR_P, CHAR_P_LO:   o_token.cls = CLS_PON;
            CHAR_O, CHAR_O_LO:   o_token.cls = CLS_POFF;
            default:             o_token.cls = CLS_OTHER;
        endcase

        o_push  = 1'b0;
        n_count = r_count;
        if (accept) begin
            if (i_rx_byte == CHAR_LF) begin
                o_token.eol = 1'b1;
                o_push      = 1'b1;
                n_count     = '0;
            end else if (i_rx_byte != CHAR_CR && room) begin
                o_push  = 1'b1;
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/smcp_fifo.sv @@
module smcp_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  smcp_pkg::t_token    i_token,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output smcp_pkg::t_token    o_token
);
    import smcp_pkg::*;

    t_token              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_token = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/smcp_back.sv @@
module smcp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tok_valid,
    input  smcp_pkg::t_token    i_token,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [2:0]          o_kind,
    output logic                o_channel,
    output logic [7:0]          o_speed,
    output logic                o_forward
);
    import smcp_pkg::*;

    t_phase      r_phase,   n_phase;
    logic [8:0]  r_acc,     n_acc;
    logic        r_channel, n_channel;
    logic [7:0]  r_speed,   n_speed;
    logic        r_forward, n_forward;
    t_kind       r_outcome, n_outcome;

    logic        r_out_valid;
    t_kind       r_out_kind;
    logic        r_out_channel;
    logic [7:0]  r_out_speed;
    logic        r_out_forward;

    logic [12:0] acc_next;
    logic        is_space;
    logic        is_digit;
    logic        out_free;
    logic        pop_eol;

    assign is_space = (i_token.cls == CLS_SPACE);
    assign is_digit = (i_token.cls == CLS_DIGIT);
    assign acc_next = 13'(r_acc) * 13'd10 + 13'(i_token.digit);
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_tok_valid && (!i_token.eol || out_free);
    assign pop_eol  = o_pop && i_token.eol;

    // Parse step; a line feed steps as a terminating non-digit before the report.
    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_channel = r_channel;
        n_speed   = r_speed;
        n_forward = r_forward;
        n_outcome = r_outcome;
        unique case (r_phase)
            PH_CMD: begin
                n_phase = PH_DONE;
                if (i_token.cls == CLS_SET) begin
                    n_phase = PH_CH_SKIP;
                end else if (i_token.cls == CLS_PON) begin
                    n_outcome = KIND_POWER_ON;
                end else if (i_token.cls == CLS_POFF) begin
                    n_outcome = KIND_POWER_OFF;
                end else begin
                    n_outcome = KIND_NONE;
                end
            end
            PH_CH_SKIP: begin
                if (is_digit) begin
                    n_acc   = 9'(i_token.digit);
                    n_phase = PH_CH_NUM;
                end else if (!is_space) begin
                    n_outcome = KIND_BAD_CH;
                    n_phase   = PH_DONE;
                end
            end
            PH_SP_SKIP: begin
                if (is_digit) begin
                    n_acc   = 9'(i_token.digit);
                    n_phase = PH_SP_NUM;
                end else if (!is_space) begin
                    n_outcome = KIND_BAD_SP;
                    n_phase   = PH_DONE;
                end
            end
            PH_DIR_SKIP: begin
                if (is_digit) begin
                    n_acc   = 9'(i_token.digit);
                    n_phase = PH_DIR_NUM;
                end else if (!is_space) begin
                    n_outcome = KIND_BAD_DIR;
                    n_phase   = PH_DONE;
                end
            end
            PH_CH_NUM: begin
                if (is_digit) begin
                    n_acc = (acc_next > 13'(ACC_SAT)) ? ACC_SAT : acc_next[8:0];
                end else if (r_acc > 9'd1) begin
                    n_outcome = KIND_BAD_CH;
                    n_phase   = PH_DONE;
                end else begin
                    // Channel closed; the same byte opens the speed field.
                    n_channel = r_acc[0];
                    if (is_space) begin
                        n_phase = PH_SP_SKIP;
                    end else begin
                        n_outcome = KIND_BAD_SP;
                        n_phase   = PH_DONE;
                    end
                end
            end
            PH_SP_NUM: begin
                if (is_digit) begin
                    n_acc = (acc_next > 13'(ACC_SAT)) ? ACC_SAT : acc_next[8:0];
                end else if (r_acc[8]) begin
                    n_outcome = KIND_BAD_SP;
                    n_phase   = PH_DONE;
                end else begin
                    n_speed = r_acc[7:0];
                    if (is_space) begin
                        n_phase = PH_DIR_SKIP;
                    end else begin
                        n_outcome = KIND_BAD_DIR;
                        n_phase   = PH_DONE;
                    end
                end
            end
            PH_DIR_NUM: begin
                if (is_digit) begin
                    n_acc = (acc_next > 13'(ACC_SAT)) ? ACC_SAT : acc_next[8:0];
                end else if (r_acc > 9'd1) begin
                    n_outcome = KIND_BAD_DIR;
                    n_phase   = PH_DONE;
                end else begin
                    n_forward = r_acc[0];
                    n_outcome = KIND_SET;
                    n_phase   = PH_DONE;
                end
            end
            PH_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || pop_eol) begin
            r_phase   <= PH_CMD;
            r_acc     <= '0;
            r_channel <= 1'b0;
            r_speed   <= '0;
            r_forward <= 1'b0;
            r_outcome <= KIND_NONE;
        end else if (o_pop) begin
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_channel <= n_channel;
            r_speed   <= n_speed;
            r_forward <= n_forward;
            r_outcome <= n_outcome;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop_eol) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_eol) begin
            r_out_kind    <= n_outcome;
            r_out_channel <= (n_outcome == KIND_SET) ? n_channel : 1'b0;
            r_out_speed   <= (n_outcome == KIND_SET) ? n_speed   : 8'd0;
            r_out_forward <= (n_outcome == KIND_SET) ? n_forward : 1'b0;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_kind    = r_out_kind;
    assign o_channel = r_out_channel;
    assign o_speed   = r_out_speed;
    assign o_forward = r_out_forward;

endmodule

@@ rtl/serial_motor_command_parser_core.sv @@
// Serial motor command parser.
// Input channel: one received character per request on i_rx_byte, taken at
// a rising edge with i_valid high and o_stall low. CR is dropped, LF closes
// the line, bytes past the line capacity are dropped until the next LF.
// Output channel: one report per line, o_kind/o_channel/o_speed/o_forward,
// taken at an edge with o_valid high and i_stall low. Channel, speed and
// forward read zero unless the kind is a set command.
// Throughput: one byte per cycle while o_stall is low. The front classifies
// each byte in the cycle it is taken and writes a token into a four-entry
// queue; the back runs the parse state machine at one token per cycle,
// except that an LF token waits while a report is held. The LF token goes
// through the queue to the back, which registers the report onto o_valid.
// Stall: a held report keeps the back from taking the next LF token, but
// plain bytes keep flowing; o_stall rises only once the queue fills.
// Reset (synchronous, active low): the queue empties, the parser waits for
// a command letter and no report is pending.
module serial_motor_command_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic        o_channel,
    output logic [7:0]  o_speed,
    output logic        o_forward
);
    import smcp_pkg::*;

    t_token push_token;
    t_token head_token;
    logic   push;
    logic   pop;
    logic   full;
    logic   head_valid;

    // Classify each byte and track the line length.
    smcp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_full    (full),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_token   (push_token)
    );

    // Decouple byte intake from the report side.
    smcp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (push_token),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_token (head_token)
    );

    // Parse tokens and hold the report in the output register.
    smcp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (head_valid),
        .i_token     (head_token),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_channel   (o_channel),
        .o_speed     (o_speed),
        .o_forward   (o_forward)
    );

endmodule
